// ----- rtl/mau_pkg.sv -----
// shared types, constants and helpers of the modular arithmetic unit
// used by mau_modmul, mau_ctrl and modular_arithmetic_unit; no dependencies
package mau_pkg;

    localparam int FW          = 30;
    localparam int OPW         = 31;
    localparam int FUNC_W      = 3;
    localparam int CNT_W       = $clog2(OPW + 1);
    localparam int IN_TDATA_W  = ((FW + OPW + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((FW + 7) / 8) * 8;

    localparam logic [FW-1:0] MODULUS_RESET   = 30'd998244353;
    localparam logic [FW-1:0] GENERATOR_RESET = 30'd3;

    localparam logic REG_MODULUS   = 1'b0;
    localparam logic REG_GENERATOR = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 3'd0,
        FN_SUB    = 3'd1,
        FN_MUL    = 3'd2,
        FN_DIV    = 3'd3,
        FN_INV    = 3'd4,
        FN_POW    = 3'd5,
        FN_ROOT   = 3'd6,
        FN_UNUSED = 3'd7
    } func_t;

    typedef struct packed {
        logic [OPW-1:0] x;
        logic [OPW-1:0] y;
        logic [OPW-1:0] d;
    } mau_req_t;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [OPW-1:0] rem;
        logic [OPW-1:0] quo;
    } mau_rsp_t;

    typedef struct packed {
        logic          valid;
        logic [FW-1:0] result;
        logic          error;
    } mau_res_t;

    function automatic mau_req_t make_req(logic [OPW-1:0] x, logic [OPW-1:0] y,
                                          logic [OPW-1:0] d);
        mau_req_t r;
        r.x = x;
        r.y = y;
        r.d = d;
        return r;
    endfunction

endpackage

// ----- rtl/mau_modmul.sv -----
// shared radix-2 shift-add-reduce unit: rem = (x * y) mod d, quo = x / d when y is one
// one bit of x per cycle; depends on mau_pkg
module mau_modmul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mau_pkg::mau_req_t  req,
    output mau_pkg::mau_rsp_t  rsp
);
    import mau_pkg::*;

    logic [OPW-1:0]   acc_reg, x_reg, y_reg, d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;

    logic [OPW+1:0] t, t1, t2, d_ext;
    logic           q;

    always_comb
    begin
        d_ext = {2'b00, d_reg};
        t     = {1'b0, acc_reg, 1'b0} + {2'b00, (x_reg[OPW-1] ? y_reg : '0)};
        q     = (t >= d_ext);
        t1    = q ? (t - d_ext) : t;
        t2    = (t1 >= d_ext) ? (t1 - d_ext) : t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(OPW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= req.x;
            y_reg   <= req.y;
            d_reg   <= req.d;
        end
        else if (busy_reg)
        begin
            acc_reg <= t2[OPW-1:0];
            x_reg   <= {x_reg[OPW-2:0], q};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = acc_reg;
    assign rsp.quo  = x_reg;

endmodule

// ----- rtl/mau_ctrl.sv -----
// sequencer: operand reduction, exponent loop and final multiply on the shared unit; add and subtract combine locally
// depends on mau_pkg; drives mau_modmul
module mau_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mau_pkg::FUNC_W-1:0]   in_func,
    input  logic [mau_pkg::FW-1:0]       in_a,
    input  logic [mau_pkg::OPW-1:0]      in_b,
    input  logic [mau_pkg::FW-1:0]       modulus,
    input  logic [mau_pkg::FW-1:0]       generator,
    output mau_pkg::mau_res_t            res,
    input  logic                         out_ready,
    output logic                         u_start,
    output mau_pkg::mau_req_t            u_req,
    input  mau_pkg::mau_rsp_t            u_rsp
);
    import mau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_RED_G,
        S_QUOT,
        S_POW_STEP,
        S_POW_MUL,
        S_POW_SQR,
        S_FIN_MUL,
        S_ADDSUB,
        S_DONE
    } state_t;

    state_t         state_reg;
    func_t          func_reg;
    logic [OPW-1:0] b_raw_reg, exp_reg;
    logic [FW-1:0]  a_reg, b_reg, base_reg, acc_reg, res_reg;
    logic           err_reg, start_reg;
    mau_req_t       req_reg;

    logic [OPW-1:0] m_ext, one_ext;
    logic [OPW-1:0] sum;
    logic [FW-1:0]  add_res, sub_res;
    func_t          in_fn;

    always_comb
    begin
        in_fn   = func_t'(in_func);
        m_ext   = {1'b0, modulus};
        one_ext = OPW'(1);
        sum     = {1'b0, a_reg} + {1'b0, b_reg};
        add_res = (sum >= m_ext) ? FW'(sum - m_ext) : sum[FW-1:0];
        sub_res = (a_reg >= b_reg) ? (a_reg - b_reg) : (a_reg + (modulus - b_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            func_reg  <= FN_ADD;
            b_raw_reg <= '0;
            exp_reg   <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            base_reg  <= '0;
            acc_reg   <= '0;
            res_reg   <= '0;
            err_reg   <= 1'b0;
            start_reg <= 1'b0;
            req_reg   <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg  <= in_fn;
                        b_raw_reg <= in_b;
                        res_reg   <= '0;
                        err_reg   <= (in_fn == FN_ROOT) && (in_b == '0);
                        acc_reg   <= FW'(1);
                        if ((modulus < FW'(2)) || (in_fn == FN_UNUSED)
                            || ((in_fn == FN_ROOT) && (in_b == '0)))
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (in_fn == FN_ROOT)
                        begin
                            start_reg <= 1'b1;
                            req_reg   <= make_req({1'b0, generator}, one_ext, m_ext);
                            state_reg <= S_RED_G;
                        end
                        else
                        begin
                            start_reg <= 1'b1;
                            req_reg   <= make_req({1'b0, in_a}, one_ext, m_ext);
                            state_reg <= S_RED_A;
                        end
                    end
                end
                S_RED_A:
                begin
                    if (u_rsp.done)
                    begin
                        a_reg    <= u_rsp.rem[FW-1:0];
                        base_reg <= u_rsp.rem[FW-1:0];
                        priority if (func_reg == FN_INV)
                        begin
                            exp_reg   <= {1'b0, modulus - FW'(2)};
                            state_reg <= (u_rsp.rem == '0) ? S_DONE : S_POW_STEP;
                        end
                        else if (func_reg == FN_POW)
                        begin
                            exp_reg   <= b_raw_reg;
                            state_reg <= S_POW_STEP;
                        end
                        else
                        begin
                            start_reg <= 1'b1;
                            req_reg   <= make_req(b_raw_reg, one_ext, m_ext);
                            state_reg <= S_RED_B;
                        end
                    end
                end
                S_RED_B:
                begin
                    if (u_rsp.done)
                    begin
                        b_reg    <= u_rsp.rem[FW-1:0];
                        base_reg <= u_rsp.rem[FW-1:0];
                        priority if (func_reg == FN_MUL)
                        begin
                            start_reg <= 1'b1;
                            req_reg   <= make_req({1'b0, a_reg}, u_rsp.rem, m_ext);
                            state_reg <= S_FIN_MUL;
                        end
                        else if (func_reg == FN_DIV)
                        begin
                            exp_reg   <= {1'b0, modulus - FW'(2)};
                            state_reg <= (u_rsp.rem == '0) ? S_DONE : S_POW_STEP;
                        end
                        else
                        begin
                            state_reg <= S_ADDSUB;
                        end
                    end
                end
                S_RED_G:
                begin
                    if (u_rsp.done)
                    begin
                        base_reg  <= u_rsp.rem[FW-1:0];
                        start_reg <= 1'b1;
                        req_reg   <= make_req({1'b0, modulus - FW'(1)}, one_ext, b_raw_reg);
                        state_reg <= S_QUOT;
                    end
                end
                S_QUOT:
                begin
                    if (u_rsp.done)
                    begin
                        exp_reg   <= u_rsp.quo;
                        state_reg <= S_POW_STEP;
                    end
                end
                S_POW_STEP:
                begin
                    priority if (exp_reg == '0)
                    begin
                        if (func_reg == FN_DIV)
                        begin
                            start_reg <= 1'b1;
                            req_reg   <= make_req({1'b0, a_reg}, {1'b0, acc_reg}, m_ext);
                            state_reg <= S_FIN_MUL;
                        end
                        else
                        begin
                            res_reg   <= acc_reg;
                            state_reg <= S_DONE;
                        end
                    end
                    else if (exp_reg[0])
                    begin
                        start_reg <= 1'b1;
                        req_reg   <= make_req({1'b0, acc_reg}, {1'b0, base_reg}, m_ext);
                        state_reg <= S_POW_MUL;
                    end
                    else
                    begin
                        start_reg <= 1'b1;
                        req_reg   <= make_req({1'b0, base_reg}, {1'b0, base_reg}, m_ext);
                        state_reg <= S_POW_SQR;
                    end
                end
                S_POW_MUL:
                begin
                    if (u_rsp.done)
                    begin
                        acc_reg   <= u_rsp.rem[FW-1:0];
                        exp_reg   <= {exp_reg[OPW-1:1], 1'b0};
                        state_reg <= S_POW_STEP;
                    end
                end
                S_POW_SQR:
                begin
                    if (u_rsp.done)
                    begin
                        base_reg  <= u_rsp.rem[FW-1:0];
                        exp_reg   <= {1'b0, exp_reg[OPW-1:1]};
                        state_reg <= S_POW_STEP;
                    end
                end
                S_FIN_MUL:
                begin
                    if (u_rsp.done)
                    begin
                        res_reg   <= u_rsp.rem[FW-1:0];
                        state_reg <= S_DONE;
                    end
                end
                S_ADDSUB:
                begin
                    res_reg   <= (func_reg == FN_SUB) ? sub_res : add_res;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res.valid  = (state_reg == S_DONE);
    assign res.result = res_reg;
    assign res.error  = err_reg;
    assign u_start    = start_reg;
    assign u_req      = req_reg;

endmodule

// ----- rtl/modular_arithmetic_unit.sv -----
// Prime-field arithmetic unit: add, subtract, multiply, divide, inverse, power, root of unity.
// Reductions and modular multiplies run on one radix-2 shift-add-reduce unit that takes
// one operand bit per cycle; add and subtract combine locally. Inverse and divide run a
// power to modulus minus 2; a root adds one division step for (modulus - 1) / count.
// One item is in work at a time; a finished result waits in the output register while
// the next item is taken. The user must write configuration (modulus, generator) only
// while the unit is idle; the block itself does not enforce it. Depends on mau_pkg,
// mau_ctrl and mau_modmul.
module modular_arithmetic_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // operand_a [29:0], operand_b [60:30], zero fill above
    input  logic [mau_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // func [2:0]
    input  logic [mau_pkg::FUNC_W-1:0]          s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // result [29:0], zero fill above
    output logic [mau_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // error [0]
    output logic                                m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_addr,
    input  logic [mau_pkg::FW-1:0]              cfg_wdata
);
    import mau_pkg::*;

    logic [FW-1:0] modulus_reg, generator_reg;
    logic          out_valid_reg;
    logic [FW-1:0] out_result_reg;
    logic          out_error_reg;
    logic          out_ready;

    mau_res_t res;
    mau_req_t u_req;
    mau_rsp_t u_rsp;
    logic     u_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= MODULUS_RESET;
            generator_reg <= GENERATOR_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MODULUS:   modulus_reg   <= cfg_wdata;
                REG_GENERATOR: generator_reg <= cfg_wdata;
                default:       modulus_reg   <= modulus_reg;
            endcase
        end
    end

    assign out_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && res.valid)
        begin
            out_result_reg <= res.result;
            out_error_reg  <= res.error;
        end
    end

    mau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_a      (s_axis_tdata[FW-1:0]),
        .in_b      (s_axis_tdata[FW+OPW-1:FW]),
        .modulus   (modulus_reg),
        .generator (generator_reg),
        .res       (res),
        .out_ready (out_ready),
        .u_start   (u_start),
        .u_req     (u_req),
        .u_rsp     (u_rsp)
    );

    mau_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (u_start),
        .req   (u_req),
        .rsp   (u_rsp)
    );

    assign m_axis_tdata  = {{(OUT_TDATA_W-FW){1'b0}}, out_result_reg};
    assign m_axis_tuser  = out_error_reg;
    assign m_axis_tvalid = out_valid_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[FW-1:0] == '0)
        else $error("error result carries a nonzero value");

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && out_ready && (modulus_reg >= FW'(2)) |-> res.result < modulus_reg)
        else $error("result not reduced below modulus");

    a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        u_start |-> !u_rsp.busy)
        else $error("shared unit launched while busy");

endmodule
